// ===== hdl/tty_line_discipline_assert.svh =====
// Assertion macros for the terminal line discipline.
// The macros expand to nothing when SYNTHESIS is defined; no other dependencies.
`ifndef TTY_LINE_DISCIPLINE_ASSERT_SVH
`define TTY_LINE_DISCIPLINE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define TLD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tld assertion failed");
// Clocked check that also holds during reset.
`define TLD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("tld assertion failed");
`else
`define TLD_ASSERT(name, clk, rst_n, prop)
`define TLD_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== hdl/tld_pkg.sv =====
// Shared types and constants for the terminal line discipline.
// Used by the front, queue, back and top-level modules; no dependencies.
package tld_pkg;

    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

    localparam logic OP_TYPE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_BACKSPACE,
        CMD_NEWLINE,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== hdl/tty_line_discipline.sv =====
// Top level of the canonical terminal line discipline.
// Depends on tld_pkg, tld_front, tld_cmd_queue and tld_back.
//
//   channel   direction   handshake              payload
//   input     in          i_valid / o_stall      i_operation, i_char_in
//   result    out         o_valid / i_stall      o_echo_valid, o_echo_char, o_line_ready,
//                                                o_read_valid, o_read_data, o_input_count
//
// A typed character, a backspace or a read of an empty ring gives its result straight
// from the back end's idle state; a read that returns a byte passes through S_READ first.
// For a newline the back end passes through S_MOVE and copies the line, newline included,
// from the line ring into the input ring one byte per cycle through its single read port.
// A two-entry command queue keeps taking items while the back end works or its result is
// stalled, until it is full. Reset is synchronous; no memory clearing pass is needed.
module tty_line_discipline #(
    parameter int RING_SIZE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_operation,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_char,
    output logic       o_line_ready,
    output logic       o_read_valid,
    output logic [7:0] o_read_data,
    output logic [7:0] o_input_count
);
    import tld_pkg::*;

    t_cmd          front_cmd;
    t_cmd          queue_cmd;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    tld_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_char_in      (i_char_in),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    tld_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (queue_status)
    );

    tld_back #(
        .RING_SIZE (RING_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_cmd_empty   (queue_status.empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_echo_valid  (o_echo_valid),
        .o_echo_char   (o_echo_char),
        .o_line_ready  (o_line_ready),
        .o_read_valid  (o_read_valid),
        .o_read_data   (o_read_data),
        .o_input_count (o_input_count)
    );

endmodule

// ===== hdl/tld_front.sv =====
// Front end: accepts input items and classifies them into commands.
// Depends on tld_pkg; feeds tld_cmd_queue.
module tld_front (
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [7:0]            i_char_in,
    input  tld_pkg::t_queue_status i_queue_status,
    output logic                  o_push,
    output tld_pkg::t_cmd         o_cmd
);
    import tld_pkg::*;

    assign o_stall = i_queue_status.full;
    assign o_push  = i_valid && !i_queue_status.full;

    always_comb begin
        o_cmd.ch = i_char_in;
        if (i_operation == OP_READ) begin
            o_cmd.kind = CMD_READ;
        end else if (i_char_in == CHAR_BACKSPACE) begin
            o_cmd.kind = CMD_BACKSPACE;
        end else if (i_char_in == CHAR_NEWLINE) begin
            o_cmd.kind = CMD_NEWLINE;
        end else begin
            o_cmd.kind = CMD_CHAR;
        end
    end

endmodule

// ===== hdl/tld_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on tld_pkg.
module tld_cmd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  tld_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output tld_pkg::t_cmd          o_cmd,
    output tld_pkg::t_queue_status o_status
);
    import tld_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_cmd          = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/tld_back.sv =====
// Back end: owns the line ring and the input ring and carries out commands.
// Depends on tld_pkg and the assertion macros in tty_line_discipline_assert.svh.
`include "tty_line_discipline_assert.svh"
module tld_back #(
    parameter int RING_SIZE = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tld_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_echo_valid,
    output logic [7:0]    o_echo_char,
    output logic          o_line_ready,
    output logic          o_read_valid,
    output logic [7:0]    o_read_data,
    output logic [7:0]    o_input_count
);
    import tld_pkg::*;

    localparam int AW = $clog2(RING_SIZE);
    localparam int LW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] LAST = AW'(RING_SIZE - 1);
    localparam logic [AW-1:0] SIZE_MOD = AW'(RING_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOVE
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        f_next = (idx == LAST) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] idx);
        f_prev = (idx == '0) ? LAST : idx - AW'(1);
    endfunction

    // Modular difference; correct for any size since the true length is below RING_SIZE.
    function automatic logic [7:0] f_count(input logic [AW-1:0] head,
                                           input logic [AW-1:0] tail);
        logic [AW-1:0] len;
        logic [LW-1:0] len_ext;
        len     = (tail >= head) ? tail - head : tail + SIZE_MOD - head;
        len_ext = LW'(len);
        f_count = (len_ext > LW'(255)) ? 8'hFF : len_ext[7:0];
    endfunction

    logic [7:0] r_line_mem [RING_SIZE];
    logic [7:0] r_input_mem [RING_SIZE];
    logic [7:0] r_line_rdata;
    logic [7:0] r_input_rdata;

    t_state        r_state, n_state;
    logic [AW-1:0] r_line_head, n_line_head;
    logic [AW-1:0] r_line_tail, n_line_tail;
    logic [AW-1:0] r_in_head, n_in_head;
    logic [AW-1:0] r_in_tail, n_in_tail;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    logic          r_echo_valid, n_echo_valid;
    logic [7:0]    r_echo_char, n_echo_char;
    logic          r_line_ready, n_line_ready;
    logic          r_read_valid, n_read_valid;
    logic [7:0]    r_read_data, n_read_data;
    logic [7:0]    r_count, n_count;

    logic          line_we;
    logic [7:0]    line_wdata;
    logic          input_we;

    logic line_full;
    logic line_empty;
    logic input_full;
    logic input_empty;
    logic take_cmd;

    assign line_full   = (f_next(r_line_tail) == r_line_head);
    assign line_empty  = (r_line_tail == r_line_head);
    assign input_full  = (f_next(r_in_tail) == r_in_head);
    assign input_empty = (r_in_tail == r_in_head);
    assign take_cmd    = (r_state == S_IDLE) && !r_out_valid && !i_cmd_empty;
    assign o_pop       = take_cmd;

    always_comb begin
        n_state      = r_state;
        n_line_head  = r_line_head;
        n_line_tail  = r_line_tail;
        n_in_head    = r_in_head;
        n_in_tail    = r_in_tail;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_stall;
        n_echo_valid = r_echo_valid;
        n_echo_char  = r_echo_char;
        n_line_ready = r_line_ready;
        n_read_valid = r_read_valid;
        n_read_data  = r_read_data;
        n_count      = r_count;
        line_we      = 1'b0;
        line_wdata   = i_cmd.ch;
        input_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take_cmd) begin
                    n_echo_valid = 1'b0;
                    n_echo_char  = 8'd0;
                    n_line_ready = 1'b0;
                    n_read_valid = 1'b0;
                    n_read_data  = 8'd0;
                    n_count      = f_count(r_in_head, r_in_tail);
                    case (i_cmd.kind)
                        CMD_CHAR: begin
                            if (!line_full) begin
                                line_we      = 1'b1;
                                n_line_tail  = f_next(r_line_tail);
                                n_echo_valid = 1'b1;
                                n_echo_char  = i_cmd.ch;
                            end
                            n_out_valid = 1'b1;
                        end
                        CMD_BACKSPACE: begin
                            if (!line_empty) begin
                                n_line_tail  = f_prev(r_line_tail);
                                n_echo_valid = 1'b1;
                                n_echo_char  = i_cmd.ch;
                            end
                            n_out_valid = 1'b1;
                        end
                        CMD_NEWLINE: begin
                            if (!line_full) begin
                                line_we      = 1'b1;
                                n_line_tail  = f_next(r_line_tail);
                                n_echo_valid = 1'b1;
                                n_echo_char  = i_cmd.ch;
                            end
                            n_line_ready = 1'b1;
                            n_pend       = 1'b0;
                            n_state      = S_MOVE;
                        end
                        CMD_READ: begin
                            if (input_empty) begin
                                n_out_valid = 1'b1;
                            end else begin
                                // The input memory is read at the head every cycle.
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_read_valid = 1'b1;
                n_read_data  = r_input_rdata;
                n_in_head    = f_next(r_in_head);
                n_count      = f_count(n_in_head, r_in_tail);
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            S_MOVE: begin
                // One line byte per cycle: the byte read last cycle is written now unless the input ring is full.
                if (r_pend && !input_full) begin
                    input_we  = 1'b1;
                    n_in_tail = f_next(r_in_tail);
                end
                if (!line_empty) begin
                    n_line_head = f_next(r_line_head);
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && line_empty) begin
                    n_count     = f_count(r_in_head, r_in_tail);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line_head <= '0;
            r_line_tail <= '0;
            r_in_head   <= '0;
            r_in_tail   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line_head <= n_line_head;
            r_line_tail <= n_line_tail;
            r_in_head   <= n_in_head;
            r_in_tail   <= n_in_tail;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_echo_valid <= n_echo_valid;
        r_echo_char  <= n_echo_char;
        r_line_ready <= n_line_ready;
        r_read_valid <= n_read_valid;
        r_read_data  <= n_read_data;
        r_count      <= n_count;
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_mem[r_line_tail] <= line_wdata;
        end
        r_line_rdata <= r_line_mem[r_line_head];
    end

    always_ff @(posedge i_clk) begin
        if (input_we) begin
            r_input_mem[r_in_tail] <= r_line_rdata;
        end
        r_input_rdata <= r_input_mem[r_in_head];
    end

    assign o_valid       = r_out_valid;
    assign o_echo_valid  = r_echo_valid;
    assign o_echo_char   = r_echo_char;
    assign o_line_ready  = r_line_ready;
    assign o_read_valid  = r_read_valid;
    assign o_read_data   = r_read_data;
    assign o_input_count = r_count;

    `TLD_ASSERT(a_idle_while_result_waits, i_clk, i_rst_n, r_out_valid |-> r_state == S_IDLE)
    `TLD_ASSERT(a_move_keeps_line_tail, i_clk, i_rst_n,
        (r_state == S_MOVE && $past(r_state) == S_MOVE) |-> $stable(r_line_tail))
    `TLD_ASSERT(a_line_empty_after_move, i_clk, i_rst_n,
        (r_out_valid && r_line_ready) |-> r_line_head == r_line_tail)
    `TLD_ASSERT(a_read_has_no_echo, i_clk, i_rst_n,
        (r_out_valid && r_read_valid) |-> !r_echo_valid && !r_line_ready)
    `TLD_ASSERT_ALWAYS(a_no_pend_outside_move, i_clk,
        (i_rst_n && r_state != S_MOVE) |-> !n_pend || take_cmd)

endmodule
